// ----- design/des_pkg.sv -----
// Package with DES permutation tables, S-boxes and the round helper functions.
package des_pkg;

    localparam int NUM_ROUNDS = 16;

    typedef struct packed {
        logic [31:0] l;
        logic [31:0] r;
    } des_lr_t;

    localparam logic [6:0] TAB_IP [64] = '{
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
        7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7};

    localparam logic [6:0] TAB_FP [64] = '{
        7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
        7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
        7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
        7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
        7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
        7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
        7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
        7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25};

    localparam logic [5:0] TAB_E [48] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
        6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
        6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
        6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
        6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
        6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1};

    localparam logic [5:0] TAB_P [32] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25};

    localparam logic [6:0] TAB_PC1 [56] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39,
        7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38,
        7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
        7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4};

    localparam logic [5:0] TAB_PC2 [48] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
        6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
        6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
        6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
        6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32};

    // Total left rotation of the C and D halves after each round.
    localparam logic [4:0] TAB_ROT_SUM [NUM_ROUNDS] = '{
        5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
        5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28};

    localparam logic [3:0] SBOX [8][64] = '{
        '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
          4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
          4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
          4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
        '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
          4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
          4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
          4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
        '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
          4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
          4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
          4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
        '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
          4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
          4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
          4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
        '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
          4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
          4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
          4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
        '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
          4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
          4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
          4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
        '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
          4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
          4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
          4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
        '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
          4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
          4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
          4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

    // Table entries count bits from the MSB starting at 1.
    function automatic logic [63:0] perm_ip(logic [63:0] x);
        logic [63:0] y;
        for (int i = 0; i < 64; i++) begin
            y[63 - i] = x[64 - int'(TAB_IP[i])];
        end
        return y;
    endfunction

    function automatic logic [63:0] perm_fp(logic [63:0] x);
        logic [63:0] y;
        for (int i = 0; i < 64; i++) begin
            y[63 - i] = x[64 - int'(TAB_FP[i])];
        end
        return y;
    endfunction

    function automatic logic [55:0] perm_pc1(logic [63:0] x);
        logic [55:0] y;
        for (int i = 0; i < 56; i++) begin
            y[55 - i] = x[64 - int'(TAB_PC1[i])];
        end
        return y;
    endfunction

    function automatic logic [27:0] rot28(logic [27:0] v, int s);
        logic [27:0] y;
        int idx;
        for (int i = 0; i < 28; i++) begin
            idx = i - s;
            if (idx < 0) begin
                idx = idx + 28;
            end
            y[i] = v[idx];
        end
        return y;
    endfunction

    function automatic logic [47:0] round_subkey(logic [55:0] cd, int round_idx);
        logic [55:0] rcd;
        logic [47:0] k;
        rcd = {rot28(cd[55:28], int'(TAB_ROT_SUM[round_idx])),
               rot28(cd[27:0], int'(TAB_ROT_SUM[round_idx]))};
        for (int i = 0; i < 48; i++) begin
            k[47 - i] = rcd[56 - int'(TAB_PC2[i])];
        end
        return k;
    endfunction

    function automatic logic [31:0] feistel(logic [31:0] r, logic [47:0] subkey);
        logic [47:0] x;
        logic [5:0] b;
        logic [31:0] s;
        logic [31:0] y;
        for (int i = 0; i < 48; i++) begin
            x[47 - i] = r[32 - int'(TAB_E[i])];
        end
        x = x ^ subkey;
        for (int i = 0; i < 8; i++) begin
            b = x[47 - 6 * i -: 6];
            s[31 - 4 * i -: 4] = SBOX[i][{b[5], b[0], b[4:1]}];
        end
        for (int i = 0; i < 32; i++) begin
            y[31 - i] = s[32 - int'(TAB_P[i])];
        end
        return y;
    endfunction

endpackage

// ----- design/des_round_cell.sv -----
// One DES Feistel round as a pipeline cell with its own valid and ready.
module des_round_cell
    import des_pkg::*;
#(
    parameter int ROUND_IDX = 0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [55:0] key_cd,
    input  logic        in_valid,
    output logic        in_ready,
    input  des_lr_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output des_lr_t     out_data
);

    logic    valid_reg;
    logic    valid_next;
    des_lr_t data_reg;
    des_lr_t data_next;
    logic    load;

    assign in_ready = ~valid_reg | out_ready;
    assign load     = in_valid & in_ready;

    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;
        data_next.l = in_data.r;
        data_next.r = in_data.l ^ feistel(in_data.r, round_subkey(key_cd, ROUND_IDX));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- design/des_block_encrypt_top.sv -----
// Top level of the pipelined DES block encryption engine.
//
// Each 64-bit word on the slave side is encrypted with standard DES under the key last written
// through cfg_we and cfg_wdata (parity bits ignored, reset value zero). Sixteen round cells form
// a chain, one Feistel round per cell. An accepted word is registered in each cell in turn,
// and its result is shown on the master side from the register of the last cell. A new word
// is accepted every cycle while the master side takes results. Each cell has its own valid
// flag, so a stall on the master side fills the empty cells before input is held off.
// The key must be written only while no word is in flight.
module des_block_encrypt_top
    import des_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,      // cipher_key
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,        // plaintext_block
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata         // ciphertext_block
);

    logic [63:0] key_reg;
    logic [55:0] key_cd;
    logic [63:0] ip_block;

    logic    valid_chain [NUM_ROUNDS + 1];
    logic    ready_chain [NUM_ROUNDS + 1];
    des_lr_t data_chain  [NUM_ROUNDS + 1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_we) begin
            key_reg <= cfg_wdata;
        end
    end

    assign key_cd   = perm_pc1(key_reg);
    assign ip_block = perm_ip(s_tdata);

    assign valid_chain[0] = s_tvalid;
    assign s_tready       = ready_chain[0];
    assign data_chain[0]  = '{l: ip_block[63:32], r: ip_block[31:0]};

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        des_round_cell #(
            .ROUND_IDX(g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .key_cd    (key_cd),
            .in_valid  (valid_chain[g]),
            .in_ready  (ready_chain[g]),
            .in_data   (data_chain[g]),
            .out_valid (valid_chain[g + 1]),
            .out_ready (ready_chain[g + 1]),
            .out_data  (data_chain[g + 1])
        );
    end

    assign ready_chain[NUM_ROUNDS] = m_tready;
    assign m_tvalid = valid_chain[NUM_ROUNDS];
    assign m_tdata  = perm_fp({data_chain[NUM_ROUNDS].r, data_chain[NUM_ROUNDS].l});

    // Input can only be held off when the last cell holds a word.
    a_stall_needs_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled while output is empty");

    // A ready sink lets the whole chain advance.
    a_ready_propagates: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is ready");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_key_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> key_reg == $past(cfg_wdata))
        else $error("key register did not take the written word");

endmodule
